// ----- rtl/core/bug2_navigation_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Bug2 navigation controller: assertion macros
// Shared property forms for the checker; clocked, and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BUG2_NAVIGATION_CONTROLLER_DEFINES_SVH
`define BUG2_NAVIGATION_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define B2_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define B2_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/b2nav_pkg.sv -----
// ----------------------------------------------------------------------------
// Bug2 navigation package
// Shared constants, mode codes, sonar flag struct and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package b2nav_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_WIDTH_DEF    = 16;

    localparam int HEAD_W  = 16;
    localparam int RANGE_W = 13;
    localparam int SPEED_W = 10;
    localparam int TURN_W  = 15;
    localparam int MODE_W  = 3;
    localparam int ATAN_W  = 22;
    localparam int IDX_W   = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_GOAL_X  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GOAL_Y  = 2'd1;
    localparam logic [IDX_W-1:0] REG_START_X = 2'd2;
    localparam logic [IDX_W-1:0] REG_START_Y = 2'd3;

    // Navigation modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEEK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEAVE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CIRCLE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAILED  = 3'd4;

    // Sonar thresholds in millimetres
    localparam logic [RANGE_W-1:0] RNG_HIT  = 13'd800;
    localparam logic [RANGE_W-1:0] RNG_NEAR = 13'd350;
    localparam logic [RANGE_W-1:0] RNG_FAR  = 13'd500;

    // Squared distance thresholds
    localparam int DG_ARRIVE = 2500;
    localparam int DG_DEPART = 10000;
    localparam int DH_CLEAR  = 250000;
    localparam int DH_RETURN = 40000;
    localparam int LINE_TOL2 = 10000;

    // Command values
    localparam logic [SPEED_W-1:0] SPD_FULL = 10'd1000;
    localparam logic [SPEED_W-1:0] SPD_WALL = 10'd500;
    localparam logic [SPEED_W-1:0] SPD_FAR  = 10'd800;
    localparam logic [TURN_W-1:0]  TURN_WALL = 15'd1000;

    // Heading error: large-error limit and binary-angle to mrad scale
    localparam int ERR_BIG   = 2086;
    localparam int ERR_SCALE = 6283;

    // Sonar classification made at entry
    typedef struct packed {
        logic fr_nz;
        logic fr_hit;
        logic lr_z;
        logic rr_near;
        logic rr_far;
    } t_flags;

    // CORDIC arctangent table, pi = 2^23
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            5'd21:   v = 22'd1;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/b2nav_front.sv -----
// ----------------------------------------------------------------------------
// Bug2 front end
// Holds the configuration, takes odometry ticks, classifies the sonar ranges,
// forms the goal and m-line differences and queues the request for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b2nav_front #(
    parameter int POS_WIDTH = b2nav_pkg::POS_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b2nav_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [POS_WIDTH-1:0]               i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [POS_WIDTH-1:0]        i_pos_x,
    input  logic signed [POS_WIDTH-1:0]        i_pos_y,
    input  logic signed [b2nav_pkg::HEAD_W-1:0] i_heading,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_front_range,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_left_range,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_right_range,
    output logic                               o_q_valid,
    input  logic                               i_q_pop,
    output logic signed [POS_WIDTH-1:0]        o_q_px,
    output logic signed [POS_WIDTH-1:0]        o_q_py,
    output logic signed [b2nav_pkg::HEAD_W-1:0] o_q_hd,
    output logic [b2nav_pkg::RANGE_W-1:0]      o_q_rr,
    output b2nav_pkg::t_flags                  o_q_fl,
    output logic signed [POS_WIDTH:0]          o_q_gdx,
    output logic signed [POS_WIDTH:0]          o_q_gdy,
    output logic signed [POS_WIDTH:0]          o_q_ex,
    output logic signed [POS_WIDTH:0]          o_q_ey,
    output logic signed [POS_WIDTH:0]          o_lx,
    output logic signed [POS_WIDTH:0]          o_ly
);

    localparam int DW = POS_WIDTH + 1;

    logic signed [POS_WIDTH-1:0] r_goal_x, r_goal_y, r_start_x, r_start_y;

    logic signed [POS_WIDTH-1:0]         r_px  [2];
    logic signed [POS_WIDTH-1:0]         r_py  [2];
    logic signed [b2nav_pkg::HEAD_W-1:0] r_hd  [2];
    logic [b2nav_pkg::RANGE_W-1:0]       r_rr  [2];
    b2nav_pkg::t_flags                   r_fl  [2];
    logic signed [DW-1:0]                r_gdx [2];
    logic signed [DW-1:0]                r_gdy [2];
    logic signed [DW-1:0]                r_ex  [2];
    logic signed [DW-1:0]                r_ey  [2];

    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    b2nav_pkg::t_flags w_fl;

    assign full      = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_push    = push && !full;
    assign w_pop     = i_q_pop && o_q_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                b2nav_pkg::REG_GOAL_X:  r_goal_x  <= i_cfg_data;
                b2nav_pkg::REG_GOAL_Y:  r_goal_y  <= i_cfg_data;
                b2nav_pkg::REG_START_X: r_start_x <= i_cfg_data;
                b2nav_pkg::REG_START_Y: r_start_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_lx = DW'(r_goal_x) - DW'(r_start_x);
    assign o_ly = DW'(r_goal_y) - DW'(r_start_y);

    // Classify the sonar ranges
    always_comb begin
        w_fl.fr_nz   = (i_front_range != '0);
        w_fl.fr_hit  = (i_front_range != '0) && (i_front_range < b2nav_pkg::RNG_HIT);
        w_fl.lr_z    = (i_left_range == '0);
        w_fl.rr_near = (i_right_range != '0) && (i_right_range < b2nav_pkg::RNG_NEAR);
        w_fl.rr_far  = (i_right_range > b2nav_pkg::RNG_FAR);
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_px[r_wp]  <= i_pos_x;
            r_py[r_wp]  <= i_pos_y;
            r_hd[r_wp]  <= i_heading;
            r_rr[r_wp]  <= i_right_range;
            r_fl[r_wp]  <= w_fl;
            r_gdx[r_wp] <= DW'(r_goal_x) - DW'(i_pos_x);
            r_gdy[r_wp] <= DW'(r_goal_y) - DW'(i_pos_y);
            r_ex[r_wp]  <= DW'(i_pos_x) - DW'(r_start_x);
            r_ey[r_wp]  <= DW'(i_pos_y) - DW'(r_start_y);
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assign o_q_px  = r_px[r_rp];
    assign o_q_py  = r_py[r_rp];
    assign o_q_hd  = r_hd[r_rp];
    assign o_q_rr  = r_rr[r_rp];
    assign o_q_fl  = r_fl[r_rp];
    assign o_q_gdx = r_gdx[r_rp];
    assign o_q_gdy = r_gdy[r_rp];
    assign o_q_ex  = r_ex[r_rp];
    assign o_q_ey  = r_ey[r_rp];

endmodule

`default_nettype wire

// ----- rtl/core/b2nav_back.sv -----
// ----------------------------------------------------------------------------
// Bug2 back end
// Sequencer with one shared multiplier for the squared distances and the
// m-line test, an iterative CORDIC for the goal bearing, the mode machine
// and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b2nav_back #(
    parameter int POS_WIDTH    = b2nav_pkg::POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = b2nav_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    output logic                               o_q_pop,
    input  logic signed [POS_WIDTH-1:0]        i_q_px,
    input  logic signed [POS_WIDTH-1:0]        i_q_py,
    input  logic signed [b2nav_pkg::HEAD_W-1:0] i_q_hd,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_q_rr,
    input  b2nav_pkg::t_flags                  i_q_fl,
    input  logic signed [POS_WIDTH:0]          i_q_gdx,
    input  logic signed [POS_WIDTH:0]          i_q_gdy,
    input  logic signed [POS_WIDTH:0]          i_q_ex,
    input  logic signed [POS_WIDTH:0]          i_q_ey,
    input  logic signed [POS_WIDTH:0]          i_lx,
    input  logic signed [POS_WIDTH:0]          i_ly,
    output logic                               empty,
    input  logic                               pop,
    output logic [b2nav_pkg::SPEED_W-1:0]      o_linear_speed,
    output logic signed [b2nav_pkg::TURN_W-1:0] o_turn_rate,
    output logic [b2nav_pkg::MODE_W-1:0]       o_mode_now,
    output logic                               o_failed
);

    localparam int DW   = POS_WIDTH + 1;
    localparam int D2W  = 2 * DW;
    localparam int CW   = D2W + 1;
    localparam int MOW  = DW + 2;
    localparam int PW   = 2 * MOW;
    localparam int C2W  = 4 * DW;
    localparam int XW   = DW + 8;
    localparam int ZW   = 25;
    localparam int LAST = (CORDIC_STEPS - 1 > 13) ? CORDIC_STEPS - 1 : 13;
    localparam int MSW  = $clog2(LAST + 1);
    localparam int SW   = b2nav_pkg::SPEED_W;
    localparam int TW   = b2nav_pkg::TURN_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Multiplier steps
    localparam logic [MSW-1:0] M_LXEY = MSW'(0);
    localparam logic [MSW-1:0] M_LYEX = MSW'(1);
    localparam logic [MSW-1:0] M_GDX2 = MSW'(2);
    localparam logic [MSW-1:0] M_GDY2 = MSW'(3);
    localparam logic [MSW-1:0] M_HDX2 = MSW'(4);
    localparam logic [MSW-1:0] M_HDY2 = MSW'(5);
    localparam logic [MSW-1:0] M_LX2  = MSW'(6);
    localparam logic [MSW-1:0] M_LY2  = MSW'(7);
    localparam logic [MSW-1:0] M_ALAL = MSW'(8);
    localparam logic [MSW-1:0] M_AHAL = MSW'(9);
    localparam logic [MSW-1:0] M_AHAH = MSW'(10);
    localparam logic [MSW-1:0] M_TLO  = MSW'(11);
    localparam logic [MSW-1:0] M_THI  = MSW'(12);
    localparam logic [MSW-1:0] M_END  = MSW'(LAST);
    localparam logic [MSW-1:0] M_CLST = MSW'(CORDIC_STEPS - 1);

    logic [2:0]     r_state;
    logic [MSW-1:0] r_ms;

    // Latched request
    logic signed [POS_WIDTH-1:0]         r_px, r_py;
    logic signed [b2nav_pkg::HEAD_W-1:0] r_hd;
    logic [b2nav_pkg::RANGE_W-1:0]       r_rr;
    b2nav_pkg::t_flags                   r_fl;
    logic signed [DW-1:0]                r_gdx, r_gdy, r_ex, r_ey, r_hdx, r_hdy;
    logic                                r_zero;

    // Navigation state
    logic [b2nav_pkg::MODE_W-1:0]        r_mode;
    logic signed [POS_WIDTH-1:0]         r_hit_x, r_hit_y;
    logic [SW-1:0]                       r_held_speed;
    logic signed [TW-1:0]                r_held_turn;

    // Multiplier datapath
    logic signed [MOW-1:0] w_ma, w_mb;
    logic signed [PW-1:0]  r_prod;
    logic [MSW-1:0]        r_tag;
    logic                  r_tv;
    logic [C2W-1:0]        w_pu;
    logic signed [CW-1:0]  r_cross;
    logic [D2W-1:0]        r_ac, r_dg, r_dh, r_l2;
    logic [C2W-1:0]        r_c2, r_t;
    logic [DW-1:0]         w_al, w_ah, w_ll, w_lh;

    // CORDIC datapath
    logic signed [XW-1:0] r_cx, r_cy, w_x0, w_xs, w_ys;
    logic signed [ZW-1:0] r_cz, w_zsum, w_atan;
    logic [4:0]           w_ci;

    // Heading error
    logic [15:0] w_theta, w_delta;
    logic [16:0] w_mag;
    logic [27:0] w_errp;
    logic [11:0] r_err;
    logic        r_big, r_neg, r_online;

    // Decision
    logic [13:0]            w_sv;
    logic [SW-1:0]          n_speed;
    logic signed [TW-1:0]   n_turn;
    logic [b2nav_pkg::MODE_W-1:0] n_mode;
    logic                   n_hit;

    // Result queue
    logic [SW-1:0]                r_os [2];
    logic signed [TW-1:0]         r_ot [2];
    logic [b2nav_pkg::MODE_W-1:0] r_om [2];
    logic       r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic       w_opush, w_opop;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && (r_ocnt != 2'd2);
    assign w_opush = (r_state == S_DONE);
    assign w_opop  = pop && !empty;

    // Split the cross magnitude and the line length for the wide squares
    assign w_al = r_ac[DW-1:0];
    assign w_ah = r_ac[D2W-1:DW];
    assign w_ll = r_l2[DW-1:0];
    assign w_lh = r_l2[D2W-1:DW];

    // Select the multiplier operands for this step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_ms)
            M_LXEY: begin w_ma = MOW'(i_lx);  w_mb = MOW'(r_ey);  end
            M_LYEX: begin w_ma = MOW'(i_ly);  w_mb = MOW'(r_ex);  end
            M_GDX2: begin w_ma = MOW'(r_gdx); w_mb = MOW'(r_gdx); end
            M_GDY2: begin w_ma = MOW'(r_gdy); w_mb = MOW'(r_gdy); end
            M_HDX2: begin w_ma = MOW'(r_hdx); w_mb = MOW'(r_hdx); end
            M_HDY2: begin w_ma = MOW'(r_hdy); w_mb = MOW'(r_hdy); end
            M_LX2:  begin w_ma = MOW'(i_lx);  w_mb = MOW'(i_lx);  end
            M_LY2:  begin w_ma = MOW'(i_ly);  w_mb = MOW'(i_ly);  end
            M_ALAL: begin w_ma = $signed(MOW'(w_al)); w_mb = $signed(MOW'(w_al)); end
            M_AHAL: begin w_ma = $signed(MOW'(w_ah)); w_mb = $signed(MOW'(w_al)); end
            M_AHAH: begin w_ma = $signed(MOW'(w_ah)); w_mb = $signed(MOW'(w_ah)); end
            M_TLO:  begin
                w_ma = $signed(MOW'(w_ll));
                w_mb = MOW'(b2nav_pkg::LINE_TOL2);
            end
            M_THI:  begin
                w_ma = $signed(MOW'(w_lh));
                w_mb = MOW'(b2nav_pkg::LINE_TOL2);
            end
            default: ;
        endcase
    end

    assign w_pu = C2W'(r_prod[PW-1:0]);

    // CORDIC step and initial rotation
    assign w_ci   = 5'(r_ms);
    assign w_xs   = r_cx >>> r_ms;
    assign w_ys   = r_cy >>> r_ms;
    assign w_atan = ZW'(b2nav_pkg::atan_entry(w_ci));
    assign w_x0   = XW'(r_gdx) <<< 6;

    // Bearing error from the CORDIC angle
    always_comb begin
        w_zsum  = r_cz + ZW'(128);
        w_theta = r_zero ? 16'd0 : w_zsum[23:8];
        w_delta = w_theta - r_hd;
        w_mag   = w_delta[15] ? (17'd0 - {1'b1, w_delta}) : {1'b0, w_delta};
        w_errp  = 28'(w_mag) * 28'(b2nav_pkg::ERR_SCALE) + 28'd32768;
    end

    // Mode machine and command
    always_comb begin
        w_sv    = r_big ? (14'(r_err) + 14'({r_err, 1'b0})) : 14'(r_err);
        n_speed = r_held_speed;
        n_turn  = r_held_turn;
        n_mode  = r_mode;
        n_hit   = 1'b0;
        unique case (r_mode)
            b2nav_pkg::MODE_SEEK: begin
                n_turn  = r_neg ? (TW'(0) - TW'(w_sv)) : TW'(w_sv);
                n_speed = r_big ? '0 : b2nav_pkg::SPD_FULL;
                if (r_dg < D2W'(b2nav_pkg::DG_ARRIVE)) begin
                    n_speed = '0;
                    n_turn  = '0;
                    n_mode  = b2nav_pkg::MODE_IDLE;
                end else if (r_fl.fr_hit) begin
                    n_hit  = 1'b1;
                    n_mode = b2nav_pkg::MODE_LEAVE;
                end
            end
            b2nav_pkg::MODE_LEAVE, b2nav_pkg::MODE_CIRCLE: begin
                priority if (r_fl.fr_nz) begin
                    n_speed = b2nav_pkg::SPD_WALL;
                    n_turn  = r_fl.lr_z ? $signed(b2nav_pkg::TURN_WALL)
                                        : (TW'(0) - $signed(b2nav_pkg::TURN_WALL));
                end else if (r_fl.rr_near) begin
                    n_turn  = $signed(b2nav_pkg::TURN_WALL) - TW'(r_rr);
                    n_speed = b2nav_pkg::SPD_FULL;
                end else if (r_fl.rr_far) begin
                    n_turn  = TW'(0) - TW'(r_rr);
                    n_speed = b2nav_pkg::SPD_FAR;
                end else begin
                end
                if (r_mode == b2nav_pkg::MODE_LEAVE) begin
                    if (r_dh > D2W'(b2nav_pkg::DH_CLEAR)) n_mode = b2nav_pkg::MODE_CIRCLE;
                end else if (r_dh < D2W'(b2nav_pkg::DH_RETURN)) begin
                    n_mode  = b2nav_pkg::MODE_FAILED;
                    n_speed = '0;
                    n_turn  = '0;
                end else if (r_online) begin
                    n_mode = b2nav_pkg::MODE_SEEK;
                end
            end
            b2nav_pkg::MODE_FAILED: begin
                n_speed = '0;
                n_turn  = '0;
            end
            default: begin
                n_mode = (r_dg > D2W'(b2nav_pkg::DG_DEPART)) ? b2nav_pkg::MODE_SEEK
                                                             : b2nav_pkg::MODE_IDLE;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ms         <= '0;
            r_tv         <= 1'b0;
            r_mode       <= b2nav_pkg::MODE_IDLE;
            r_hit_x      <= '0;
            r_hit_y      <= '0;
            r_held_speed <= '0;
            r_held_turn  <= '0;
        end else begin
            r_tv <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_q_pop) r_state <= S_PREP;
                S_PREP: begin
                    r_ms    <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_tv <= (r_ms <= M_THI);
                    r_ms <= r_ms + MSW'(1);
                    if (r_ms == M_END) r_state <= S_EVAL;
                end
                S_EVAL: r_state <= S_DONE;
                S_DONE: begin
                    r_mode       <= n_mode;
                    r_held_speed <= n_speed;
                    r_held_turn  <= n_turn;
                    if (n_hit) begin
                        r_hit_x <= r_px;
                        r_hit_y <= r_py;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_px   <= i_q_px;
            r_py   <= i_q_py;
            r_hd   <= i_q_hd;
            r_rr   <= i_q_rr;
            r_fl   <= i_q_fl;
            r_gdx  <= i_q_gdx;
            r_gdy  <= i_q_gdy;
            r_ex   <= i_q_ex;
            r_ey   <= i_q_ey;
            r_zero <= (i_q_gdx == '0) && (i_q_gdy == '0);
        end

        // Hit offsets and the CORDIC starting vector
        if (r_state == S_PREP) begin
            r_hdx <= DW'(r_px) - DW'(r_hit_x);
            r_hdy <= DW'(r_py) - DW'(r_hit_y);
            if (w_x0 < 0) begin
                if (r_gdy >= 0) begin
                    r_cx <= XW'(r_gdy) <<< 6;
                    r_cy <= XW'(0) - w_x0;
                    r_cz <= ZW'(4194304);
                end else begin
                    r_cx <= XW'(0) - (XW'(r_gdy) <<< 6);
                    r_cy <= w_x0;
                    r_cz <= ZW'(-4194304);
                end
            end else begin
                r_cx <= w_x0;
                r_cy <= XW'(r_gdy) <<< 6;
                r_cz <= '0;
            end
        end

        // Advance the CORDIC one step a cycle
        if (r_state == S_RUN && r_ms <= M_CLST) begin
            if (r_cy > 0) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end
        end

        // Multiply, then accumulate by the tag of the previous step
        r_prod <= w_ma * w_mb;
        r_tag  <= r_ms;
        r_ac   <= r_cross[CW-1] ? D2W'(-r_cross) : D2W'(r_cross);
        if (r_tv) begin
            unique case (r_tag)
                M_LXEY: r_cross <= r_prod[CW-1:0];
                M_LYEX: r_cross <= r_cross - $signed(r_prod[CW-1:0]);
                M_GDX2: r_dg    <= r_prod[D2W-1:0];
                M_GDY2: r_dg    <= r_dg + r_prod[D2W-1:0];
                M_HDX2: r_dh    <= r_prod[D2W-1:0];
                M_HDY2: r_dh    <= r_dh + r_prod[D2W-1:0];
                M_LX2:  r_l2    <= r_prod[D2W-1:0];
                M_LY2:  r_l2    <= r_l2 + r_prod[D2W-1:0];
                M_ALAL: r_c2    <= w_pu;
                M_AHAL: r_c2    <= r_c2 + (w_pu << (DW + 1));
                M_AHAH: r_c2    <= r_c2 + (w_pu << D2W);
                M_TLO:  r_t     <= w_pu;
                M_THI:  r_t     <= r_t + (w_pu << DW);
                default: ;
            endcase
        end

        // Register the heading error and the line test
        if (r_state == S_EVAL) begin
            r_err    <= w_errp[27:16];
            r_big    <= (w_mag > 17'(b2nav_pkg::ERR_BIG));
            r_neg    <= w_delta[15];
            r_online <= (r_c2 < r_t);
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_os[r_owp] <= n_speed;
            r_ot[r_owp] <= n_turn;
            r_om[r_owp] <= n_mode;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) r_owp <= ~r_owp;
            if (w_opop)  r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_opush} - {1'b0, w_opop};
        end
    end

    assign empty          = (r_ocnt == 2'd0);
    assign o_linear_speed = r_os[r_orp];
    assign o_turn_rate    = r_ot[r_orp];
    assign o_mode_now     = r_om[r_orp];
    assign o_failed       = (r_om[r_orp] == b2nav_pkg::MODE_FAILED);

endmodule

`default_nettype wire

// ----- rtl/core/bug2_navigation_controller.sv -----
// The back end takes a new tick only after it has pushed the previous result and
// while the result queue has room; its pace is set by the shared multiplier
// sequence and the one-step-a-cycle CORDIC. A finished result shows as empty low.
// Up to two ticks and two results queue on either side.
// Reset (synchronous, active low) clears modes, hit point, held command, queues.
// ----------------------------------------------------------------------------
// Bug2 navigation controller
// Front end queues classified ticks; back end runs the Bug2 mode machine.
// ----------------------------------------------------------------------------
`default_nettype none

module bug2_navigation_controller #(
    parameter int CORDIC_STEPS = b2nav_pkg::CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = b2nav_pkg::POS_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b2nav_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [POS_WIDTH-1:0]               i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [POS_WIDTH-1:0]        i_pos_x,
    input  logic signed [POS_WIDTH-1:0]        i_pos_y,
    input  logic signed [b2nav_pkg::HEAD_W-1:0] i_heading,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_front_range,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_left_range,
    input  logic [b2nav_pkg::RANGE_W-1:0]      i_right_range,
    output logic                               empty,
    input  logic                               pop,
    output logic [b2nav_pkg::SPEED_W-1:0]      o_linear_speed,
    output logic signed [b2nav_pkg::TURN_W-1:0] o_turn_rate,
    output logic [b2nav_pkg::MODE_W-1:0]       o_mode_now,
    output logic                               o_failed
);

    logic                                q_valid, q_pop;
    logic signed [POS_WIDTH-1:0]         q_px, q_py;
    logic signed [b2nav_pkg::HEAD_W-1:0] q_hd;
    logic [b2nav_pkg::RANGE_W-1:0]       q_rr;
    b2nav_pkg::t_flags                   q_fl;
    logic signed [POS_WIDTH:0]           q_gdx, q_gdy, q_ex, q_ey, lx, ly;

    // Front end: configuration, classification and request queue
    b2nav_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_heading(i_heading),
        .i_front_range(i_front_range), .i_left_range(i_left_range),
        .i_right_range(i_right_range),
        .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_px(q_px), .o_q_py(q_py), .o_q_hd(q_hd), .o_q_rr(q_rr), .o_q_fl(q_fl),
        .o_q_gdx(q_gdx), .o_q_gdy(q_gdy), .o_q_ex(q_ex), .o_q_ey(q_ey),
        .o_lx(lx), .o_ly(ly)
    );

    // Back end: arithmetic sequencer, mode machine and result queue
    b2nav_back #(.POS_WIDTH(POS_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_px(q_px), .i_q_py(q_py), .i_q_hd(q_hd), .i_q_rr(q_rr), .i_q_fl(q_fl),
        .i_q_gdx(q_gdx), .i_q_gdy(q_gdy), .i_q_ex(q_ex), .i_q_ey(q_ey),
        .i_lx(lx), .i_ly(ly),
        .empty(empty), .pop(pop),
        .o_linear_speed(o_linear_speed), .o_turn_rate(o_turn_rate),
        .o_mode_now(o_mode_now), .o_failed(o_failed)
    );

endmodule

`default_nettype wire

// ----- rtl/core/b2nav_chk.sv -----
// ----------------------------------------------------------------------------
// Bug2 result checker
// Watches the result side of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bug2_navigation_controller_defines.svh"

module b2nav_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               empty,
    input wire logic                               pop,
    input wire logic [b2nav_pkg::SPEED_W-1:0]      o_linear_speed,
    input wire logic signed [b2nav_pkg::TURN_W-1:0] o_turn_rate,
    input wire logic [b2nav_pkg::MODE_W-1:0]       o_mode_now,
    input wire logic                               o_failed
);

    // Failed flag tracks the failed mode
    `B2_ASSERT_NOW(a_failed_flag, i_clk, i_rst_n, !empty,
        o_failed == (o_mode_now == b2nav_pkg::MODE_FAILED), "failed flag mismatch")

    // Failed mode commands a stop
    `B2_ASSERT_NOW(a_failed_stop, i_clk, i_rst_n, !empty && o_failed,
        o_linear_speed == '0 && o_turn_rate == '0, "failed mode not stopped")

    // Commands stay within their limits
    `B2_ASSERT_NOW(a_cmd_range, i_clk, i_rst_n, !empty,
        o_linear_speed <= b2nav_pkg::SPD_FULL && o_turn_rate <= 15'sd10000 && o_turn_rate >= -15'sd10000, "command out of range")

    // Hold a waiting result
    `B2_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_turn_rate) && $stable(o_linear_speed) && $stable(o_mode_now), "result changed while waiting")

endmodule

bind bug2_navigation_controller b2nav_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_linear_speed(o_linear_speed), .o_turn_rate(o_turn_rate),
    .o_mode_now(o_mode_now), .o_failed(o_failed)
);

`default_nettype wire

// ----- bench/bug2_navigation_controller_test.sv -----
// ----------------------------------------------------------------------------
// Bug2 navigation controller testbench
// Drives odometry ticks through the push/full port and drains commands through
// empty/pop. A scoreboard predicts each command from its own Bug2 mode machine
// and compares every field. Goal and start are reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bug2_navigation_controller_test;
    import b2nav_pkg::*;

    typedef struct {
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic signed [15:0]  heading;
        logic [RANGE_W-1:0]  front;
        logic [RANGE_W-1:0]  left;
        logic [RANGE_W-1:0]  right;
    } tick_t;

    typedef struct {
        logic [SPEED_W-1:0]        speed;
        logic signed [TURN_W-1:0]  turn;
        logic [MODE_W-1:0]         mode;
        logic                      failed;
    } command_t;

    // Bug2 command predictor with queue of commands still to arrive
    class nav_scoreboard;
        longint goal_x, goal_y, start_x, start_y;
        longint hit_x, hit_y;
        longint speed_hold, turn_hold;
        logic [MODE_W-1:0] mode;
        command_t pending[$];
        int mismatches;
        longint atan_steps[24] = '{
            2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
            10430, 5215, 2608, 1304, 652, 326, 163, 81,
            41, 20, 10, 5, 3, 1, 1, 0};

        function new();
            goal_x = 0; goal_y = 0; start_x = 0; start_y = 0;
            hit_x = 0; hit_y = 0; speed_hold = 0; turn_hold = 0;
            mode = MODE_IDLE;
            mismatches = 0;
        endfunction

        function longint wrap16(longint v);
            logic signed [15:0] t;
            t = v[15:0];
            return t;
        endfunction

        function longint sq_dist(longint ax, longint ay, longint bx, longint by);
            return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
        endfunction

        function longint clip_turn(longint v);
            if (v > 10000) return 10000;
            if (v < -10000) return -10000;
            return v;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
            longint v;
            v = wrap16(data);
            case (idx)
                REG_GOAL_X:  goal_x = v;
                REG_GOAL_Y:  goal_y = v;
                REG_START_X: start_x = v;
                REG_START_Y: start_y = v;
                default: ;
            endcase
        endfunction

        // CORDIC vectoring: bearing as binary angle
        function longint bearing(longint dx, longint dy);
            longint x, y, z, t, xs, ys;
            x = dx * 64; y = dy * 64; z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 4194304;
                end else begin
                    x = -y; y = t; z = -4194304;
                end
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z += atan_steps[i];
                end else begin
                    x = x - ys; y = y + xs; z -= atan_steps[i];
                end
            end
            return wrap16((z + 128) >>> 8);
        endfunction

        function void steer_to_goal(longint px, longint py, longint hd);
            longint delta, mag, err;
            delta = wrap16(bearing(goal_x - px, goal_y - py) - hd);
            mag = delta < 0 ? -delta : delta;
            err = (mag * 6283 + 32768) >>> 16;
            if (delta < 0) err = -err;
            if (mag > 2086) begin
                turn_hold = clip_turn(err * 3);
                speed_hold = 0;
            end else begin
                turn_hold = clip_turn(err);
                speed_hold = 1000;
            end
        endfunction

        function void wall_rules(longint fr, longint lr, longint rr);
            if (fr > 0) begin
                speed_hold = 500;
                turn_hold = (lr == 0) ? 1000 : -1000;
            end else if (rr > 0 && rr < 350) begin
                turn_hold = 1000 - rr;
                speed_hold = 1000;
            end else if (rr > 500) begin
                turn_hold = -rr;
                speed_hold = 800;
            end
        endfunction

        function bit near_mline(longint px, longint py);
            longint lx, ly, cr;
            logic [127:0] ac, l2;
            lx = goal_x - start_x;
            ly = goal_y - start_y;
            cr = lx * (py - start_y) - ly * (px - start_x);
            ac = 128'(cr < 0 ? -cr : cr);
            l2 = 128'(lx * lx + ly * ly);
            return (ac * ac) < (l2 * 10000);
        endfunction

        // Advance the mode machine by one accepted tick
        function void note_tick(tick_t t);
            longint px, py, dg, dh;
            command_t c;
            px = t.pos_x; py = t.pos_y;
            dg = sq_dist(px, py, goal_x, goal_y);
            dh = sq_dist(px, py, hit_x, hit_y);
            case (mode)
                MODE_SEEK: begin
                    steer_to_goal(px, py, t.heading);
                    if (dg < 2500) begin
                        speed_hold = 0; turn_hold = 0; mode = MODE_IDLE;
                    end else if (t.front > 0 && t.front < 800) begin
                        hit_x = px; hit_y = py; mode = MODE_LEAVE;
                    end
                end
                MODE_LEAVE: begin
                    wall_rules(t.front, t.left, t.right);
                    if (dh > 250000) mode = MODE_CIRCLE;
                end
                MODE_CIRCLE: begin
                    wall_rules(t.front, t.left, t.right);
                    if (dh < 40000) begin
                        mode = MODE_FAILED; speed_hold = 0; turn_hold = 0;
                    end else if (near_mline(px, py)) begin
                        mode = MODE_SEEK;
                    end
                end
                MODE_FAILED: begin
                    speed_hold = 0; turn_hold = 0;
                end
                default: begin
                    mode = (dg > 10000) ? MODE_SEEK : MODE_IDLE;
                end
            endcase
            c.speed = speed_hold[SPEED_W-1:0];
            c.turn = turn_hold[TURN_W-1:0];
            c.mode = mode;
            c.failed = (mode == MODE_FAILED);
            pending = {pending, c};
        endfunction

        function void check_command(command_t got);
            command_t exp_c;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command: speed %0d turn %0d mode %0d",
                             got.speed, got.turn, got.mode);
                return;
            end
            exp_c = pending.pop_front();
            if (got.speed !== exp_c.speed || got.turn !== exp_c.turn ||
                got.mode !== exp_c.mode || got.failed !== exp_c.failed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("command mismatch: exp spd %0d trn %0d mode %0d fail %0b, got spd %0d trn %0d mode %0d fail %0b",
                             exp_c.speed, exp_c.turn, exp_c.mode, exp_c.failed,
                             got.speed, got.turn, got.mode, got.failed);
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [IDX_W-1:0]          i_cfg_idx;
    logic [15:0]               i_cfg_data;
    logic                      push;
    logic                      full;
    logic signed [15:0]        i_pos_x;
    logic signed [15:0]        i_pos_y;
    logic signed [15:0]        i_heading;
    logic [RANGE_W-1:0]        i_front_range;
    logic [RANGE_W-1:0]        i_left_range;
    logic [RANGE_W-1:0]        i_right_range;
    logic                      empty;
    logic                      pop;
    logic [SPEED_W-1:0]        o_linear_speed;
    logic signed [TURN_W-1:0]  o_turn_rate;
    logic [MODE_W-1:0]         o_mode_now;
    logic                      o_failed;

    nav_scoreboard sb = new();
    int  gap_pct;
    int  stall_pct;
    bit  allow_fail;
    longint cur_x, cur_y;

    bug2_navigation_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_heading(i_heading),
        .i_front_range(i_front_range), .i_left_range(i_left_range),
        .i_right_range(i_right_range),
        .empty(empty), .pop(pop),
        .o_linear_speed(o_linear_speed), .o_turn_rate(o_turn_rate),
        .o_mode_now(o_mode_now), .o_failed(o_failed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drain commands with random stalls
    always @(negedge i_clk)
        pop <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge i_clk) begin
        command_t c;
        if (i_rst_n && pop && !empty) begin
            c.speed = o_linear_speed;
            c.turn = o_turn_rate;
            c.mode = o_mode_now;
            c.failed = o_failed;
            sb.check_command(c);
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Program goal and start once the block has gone quiet
    task automatic set_route(logic [15:0] gx, logic [15:0] gy,
                             logic [15:0] sx, logic [15:0] sy);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send one tick, holding it until the block takes the request
    task automatic send_tick(tick_t t);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        i_pos_x = t.pos_x;
        i_pos_y = t.pos_y;
        i_heading = t.heading;
        i_front_range = t.front;
        i_left_range = t.left;
        i_right_range = t.right;
        push = 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_tick(t);
    endtask

    task automatic send_fields(longint x, longint y, longint h,
                               int fr, int lr, int rr);
        tick_t t;
        t.pos_x = x[15:0]; t.pos_y = y[15:0]; t.heading = h[15:0];
        t.front = fr[12:0]; t.left = lr[12:0]; t.right = rr[12:0];
        send_tick(t);
    endtask

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int pick_range();
        case ($urandom_range(0, 5))
            0, 1:    return 0;
            2:       return $urandom_range(1, 799);
            3:       return $urandom_range(300, 520);
            4:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 1200);
        endcase
    endfunction

    // Mostly a wandering robot near the route; some noise
    task automatic send_random_tick();
        tick_t t;
        int r;
        longint hx, hy;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            t.pos_x = 16'($urandom); t.pos_y = 16'($urandom); t.heading = 16'($urandom);
            t.front = 13'($urandom); t.left = 13'($urandom); t.right = 13'($urandom);
            send_tick(t);
            return;
        end
        if (r < 16) begin
            r = $urandom_range(0, 100);
            cur_x = sb.start_x + (sb.goal_x - sb.start_x) * r / 100;
            cur_y = sb.start_y + (sb.goal_y - sb.start_y) * r / 100;
        end else if (r < 21) begin
            cur_x = sb.goal_x + $urandom_range(0, 80) - 40;
            cur_y = sb.goal_y + $urandom_range(0, 80) - 40;
        end else if (r < 28) begin
            cur_x += $urandom_range(0, 2000) - 1000;
            cur_y += $urandom_range(0, 2000) - 1000;
        end else begin
            cur_x += $urandom_range(0, 300) - 150;
            cur_y += $urandom_range(0, 300) - 150;
        end
        // keep clear of the hit point unless a failure is wanted
        hx = sb.hit_x; hy = sb.hit_y;
        if (sb.mode == MODE_CIRCLE) begin
            if (allow_fail && $urandom_range(0, 3) == 0) begin
                cur_x = hx + $urandom_range(0, 200) - 100;
                cur_y = hy;
            end else if (!allow_fail && sb.sq_dist(cur_x, cur_y, hx, hy) < 90000) begin
                cur_x = (hx > 0) ? hx - 700 : hx + 700;
            end
        end
        cur_x = clamp16(cur_x);
        cur_y = clamp16(cur_y);
        t.pos_x = cur_x[15:0];
        t.pos_y = cur_y[15:0];
        t.heading = 16'($urandom);
        t.front = (sb.mode == MODE_SEEK && $urandom_range(0, 2) != 0) ? 13'd0
                                                                      : 13'(pick_range());
        t.left = 13'(pick_range());
        t.right = 13'(pick_range());
        send_tick(t);
    endtask

    task automatic run_phase(int gap, int stall, int count);
        gap_pct = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            if (count > 200 && n == count / 2 && gap == 22) allow_fail = 1'b1;
            send_random_tick();
        end
        @(negedge i_clk);
        push = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_GOAL_X;
        i_cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_heading = '0;
        i_front_range = '0; i_left_range = '0; i_right_range = '0;
        gap_pct = 0;
        stall_pct = 0;
        allow_fail = 1'b0;
        cur_x = 0; cur_y = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: goal and start both at the origin
        send_fields(0, 0, 0, 0, 0, 0);                       // idle, goal close
        send_fields(32767, -32768, 32767, 8191, 8191, 8191); // idle to seek
        send_fields(0, 0, -32768, 0, 0, 0);                  // zero vector, arrive
        send_fields(5000, 0, 0, 0, 0, 0);                    // seek again
        send_fields(-32768, 32767, -32768, 0, 8191, 0);      // big heading error
        send_fields(200, 0, 32767, 800, 0, 0);               // front at limit
        send_fields(150, 40, 0, 799, 0, 0);                  // hit, leave
        send_fields(300, 40, 0, 8191, 0, 0);                 // front, left clear
        send_fields(300, 40, 0, 1, 5, 0);                    // front, left wall
        send_fields(300, 40, 0, 0, 0, 349);
        send_fields(300, 40, 0, 0, 0, 1);
        send_fields(300, 40, 0, 0, 0, 350);                  // hold
        send_fields(300, 40, 0, 0, 0, 500);                  // hold
        send_fields(300, 40, 0, 0, 0, 501);
        send_fields(300, 40, 0, 0, 0, 8191);
        send_fields(2000, 40, 0, 0, 0, 0);                   // to circling
        send_fields(2000, 0, 0, 0, 0, 0);                    // start equals goal
        send_fields(-2000, 0, 0, 0, 4000, 200);
        send_fields(0, 3000, 0, 0, 8191, 8191);
        @(negedge i_clk);
        push = 1'b0;

        set_route(16'sd3000, 16'sd2000, 16'sd0, 16'sd0);
        run_phase(0, 0, 420);
        set_route(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        cur_x = 0; cur_y = 0;
        run_phase(75, 0, 420);
        set_route(16'sd1500, -16'sd1500, 16'sd1500, -16'sd1500);
        run_phase(0, 75, 420);
        set_route(-16'sd5000, 16'sd4000, 16'sd1000, -16'sd1000);
        run_phase(22, 22, 420);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hang guard
    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
